// ===== rtl/core/ttf_pkg.sv =====
// ttf_pkg: widths, types and small helpers shared by the tangent frame block
// used by ttf_mul, ttf_sqdiv and triangle_tangent_frame; no dependencies

package ttf_pkg;

   localparam int COORD_BITS = 16;
   localparam int TEX_BITS   = 16;
   localparam int NORM_BITS  = 16;
   localparam int OUT_BITS   = 16;

   // edge and uv delta widths, raw tangent/bitangent/determinant width
   localparam int E_BITS   = COORD_BITS + 1;
   localparam int D_BITS   = TEX_BITS + 1;
   localparam int RAW_BITS = E_BITS + D_BITS + 1;
   localparam int MAG_BITS = RAW_BITS - 1;

   // normalisation windows
   localparam int TAN_TOP = 29;
   localparam int BIT_TOP = 14;

   // shared multiplier
   localparam int MUL_BITS  = 32;
   localparam int PROD_BITS = 2 * MUL_BITS;

   // root and divide
   localparam int SUM_BITS   = 2 * (TAN_TOP + 1) + 2;
   localparam int ROOT_BITS  = TAN_TOP + 2;
   localparam int UNIT_SHIFT = 15;
   localparam int NUM_BITS   = TAN_TOP + 1 + UNIT_SHIFT + 1;
   localparam int DEN_BITS   = ROOT_BITS + 1;
   localparam int QUO_BITS   = 15;
   localparam int ACC_BITS   = 64;
   localparam int ROOT_STEPS = 32;
   localparam int DIV_STEPS  = 16;
   localparam int CNT_BITS   = $clog2(ROOT_STEPS);

   // handedness test
   localparam int CR_BITS  = 32;
   localparam int DOT_BITS = 50;

   // sequencer
   localparam int STEP_BITS  = 4;
   localparam int PROD_OPS   = 14;
   localparam int SQ_OPS     = 3;
   localparam int CORNER_END = 9;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
      logic signed [TEX_BITS-1:0]   tex_u;
      logic signed [TEX_BITS-1:0]   tex_v;
      logic signed [NORM_BITS-1:0]  norm_x;
      logic signed [NORM_BITS-1:0]  norm_y;
      logic signed [NORM_BITS-1:0]  norm_z;
   } corner_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_ABS,
      ST_SCALE_T,
      ST_SQ,
      ST_ROOT,
      ST_DIV,
      ST_SCALE_B,
      ST_CORNER,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic is_root;
   } sqdiv_cmd_type;

   function automatic logic signed [COORD_BITS-1:0] pos_at(input corner_type c,
                                                          input logic [1:0] axis);
      logic signed [COORD_BITS-1:0] v;
      case (axis)
         2'd0:    v = c.pos_x;
         2'd1:    v = c.pos_y;
         default: v = c.pos_z;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/triangle_tangent_frame.sv =====
// triangle_tangent_frame: per-triangle tangent and handedness, top level
// depends on ttf_pkg, ttf_mul and ttf_sqdiv
//
//   channel  dir  handshake            payload
//   req_     in   req_valid/req_stall  position, uv and normal of one corner
//   rsp_     out  rsp_valid/rsp_stall  tangent, handedness, flags per corner
//
// first and second corner: stored, no result
// third corner: worked through the one shared 32x32 multiplier (14 products,
//   3 squares, 9 per corner), the one-bit-a-cycle normalising shifts, and the
//   compare-subtract unit (32 root steps, 16 per divide); a degenerate
//   triangle skips the shifts, root and divide
// reset clears the corner count and sequencer; held corners are not cleared
// req_stall is high from the third corner until its last result transfer;
//   a stalled result holds until taken

module triangle_tangent_frame (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [ttf_pkg::COORD_BITS-1:0]  req_pos_x,
   input  logic signed [ttf_pkg::COORD_BITS-1:0]  req_pos_y,
   input  logic signed [ttf_pkg::COORD_BITS-1:0]  req_pos_z,
   input  logic signed [ttf_pkg::TEX_BITS-1:0]    req_tex_u,
   input  logic signed [ttf_pkg::TEX_BITS-1:0]    req_tex_v,
   input  logic signed [ttf_pkg::NORM_BITS-1:0]   req_norm_x,
   input  logic signed [ttf_pkg::NORM_BITS-1:0]   req_norm_y,
   input  logic signed [ttf_pkg::NORM_BITS-1:0]   req_norm_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ttf_pkg::OUT_BITS-1:0]    rsp_tangent_x,
   output logic signed [ttf_pkg::OUT_BITS-1:0]    rsp_tangent_y,
   output logic signed [ttf_pkg::OUT_BITS-1:0]    rsp_tangent_z,
   output logic                                   rsp_handed_negative,
   output logic                                   rsp_degenerate,
   output logic                                   rsp_last_corner
);
   import ttf_pkg::*;

   // sequencer
   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [1:0]           comp_ff, comp_in;
   logic [1:0]           count_ff, count_in;

   // corner storage
   corner_type held_ff [2];
   corner_type held_in [2];
   corner_type last_ff, last_in;
   corner_type req_corner, cur;

   // raw products and their magnitudes
   logic signed [RAW_BITS-1:0] det_ff, det_in, tmp_ff, tmp_in;
   logic signed [RAW_BITS-1:0] tr_ff [3];
   logic signed [RAW_BITS-1:0] tr_in [3];
   logic signed [RAW_BITS-1:0] br_ff [3];
   logic signed [RAW_BITS-1:0] br_in [3];
   logic [MAG_BITS-1:0]        tm_ff [3];
   logic [MAG_BITS-1:0]        tm_in [3];
   logic [MAG_BITS-1:0]        bm_ff [3];
   logic [MAG_BITS-1:0]        bm_in [3];
   logic [2:0]                 tneg_ff, tneg_in, bneg_ff, bneg_in;
   logic                       degen_ff, degen_in;
   logic [SUM_BITS-1:0]        sum_ff, sum_in;
   logic [ROOT_BITS-1:0]       len_ff, len_in;

   // final tangent, scaled bitangent, cross product and dot product
   logic signed [OUT_BITS-1:0] t_ff [3];
   logic signed [OUT_BITS-1:0] t_in [3];
   logic signed [OUT_BITS-1:0] b_ff [3];
   logic signed [OUT_BITS-1:0] b_in [3];
   logic signed [CR_BITS-1:0]  c_ff [3];
   logic signed [CR_BITS-1:0]  c_in [3];
   logic signed [DOT_BITS-1:0] d_ff, d_in;

   // result register
   logic signed [OUT_BITS-1:0] rt_ff [3];
   logic signed [OUT_BITS-1:0] rt_in [3];
   logic rhand_ff, rhand_in, rdegen_ff, rdegen_in, rlast_ff, rlast_in;

   // shared units
   logic signed [MUL_BITS-1:0]  mul_a, mul_b;
   logic signed [PROD_BITS-1:0] prod_ff;
   sqdiv_cmd_type               sq_cmd;
   logic [NUM_BITS-1:0]         sq_num;
   logic [DEN_BITS-1:0]         sq_den;
   logic                        sq_done;
   logic [ACC_BITS-1:0]         sq_res;

   // edges and uv deltas
   logic signed [E_BITS-1:0] e1 [3];
   logic signed [E_BITS-1:0] e2 [3];
   logic signed [D_BITS-1:0] du1, dv1, du2, dv2;

   // working values
   logic signed [RAW_BITS-1:0] trs, brs, diff_raw;
   logic [MAG_BITS-1:0]        tall, ball;
   logic [2:0]                 ret_idx;
   logic [QUO_BITS-1:0]        quo;
   logic signed [OUT_BITS-1:0] qs;
   logic signed [DOT_BITS-1:0] dsum;
   logic [1:0]                 ci;

   ttf_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   ttf_sqdiv u_sqdiv (
      .clock    (clock),
      .reset    (reset),
      .cmd      (sq_cmd),
      .root_arg (sum_ff),
      .num      (sq_num),
      .den      (sq_den),
      .done_ff  (sq_done),
      .res_ff   (sq_res)
   );

   assign req_corner = '{pos_x: req_pos_x, pos_y: req_pos_y, pos_z: req_pos_z,
                         tex_u: req_tex_u, tex_v: req_tex_v,
                         norm_x: req_norm_x, norm_y: req_norm_y, norm_z: req_norm_z};

   // corner for the handedness pass, in arrival order
   always_comb begin
      case (comp_ff)
         2'd0:    cur = held_ff[0];
         2'd1:    cur = held_ff[1];
         default: cur = last_ff;
      endcase
   end

   assign du1 = D_BITS'(held_ff[1].tex_u) - D_BITS'(held_ff[0].tex_u);
   assign dv1 = D_BITS'(held_ff[1].tex_v) - D_BITS'(held_ff[0].tex_v);
   assign du2 = D_BITS'(last_ff.tex_u) - D_BITS'(held_ff[0].tex_u);
   assign dv2 = D_BITS'(last_ff.tex_v) - D_BITS'(held_ff[0].tex_v);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1[i] = E_BITS'(pos_at(held_ff[1], 2'(i))) - E_BITS'(pos_at(held_ff[0], 2'(i)));
         e2[i] = E_BITS'(pos_at(last_ff, 2'(i))) - E_BITS'(pos_at(held_ff[0], 2'(i)));
      end
   end

   // divider operands: (mag * 32768 + len) / (2 * len)
   assign sq_num = NUM_BITS'({tm_ff[comp_ff][TAN_TOP:0], {UNIT_SHIFT{1'b0}}})
                   + NUM_BITS'(len_ff);
   assign sq_den = {len_ff, 1'b0};

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_tangent_x       = rt_ff[0];
   assign rsp_tangent_y       = rt_ff[1];
   assign rsp_tangent_z       = rt_ff[2];
   assign rsp_handed_negative = rhand_ff;
   assign rsp_degenerate      = rdegen_ff;
   assign rsp_last_corner     = rlast_ff;

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_PROD: begin
            case (step_ff)
               4'd0:    begin mul_a = MUL_BITS'(du1);   mul_b = MUL_BITS'(dv2); end
               4'd1:    begin mul_a = MUL_BITS'(du2);   mul_b = MUL_BITS'(dv1); end
               4'd2:    begin mul_a = MUL_BITS'(e1[0]); mul_b = MUL_BITS'(dv2); end
               4'd3:    begin mul_a = MUL_BITS'(e2[0]); mul_b = MUL_BITS'(dv1); end
               4'd4:    begin mul_a = MUL_BITS'(e1[1]); mul_b = MUL_BITS'(dv2); end
               4'd5:    begin mul_a = MUL_BITS'(e2[1]); mul_b = MUL_BITS'(dv1); end
               4'd6:    begin mul_a = MUL_BITS'(e1[2]); mul_b = MUL_BITS'(dv2); end
               4'd7:    begin mul_a = MUL_BITS'(e2[2]); mul_b = MUL_BITS'(dv1); end
               4'd8:    begin mul_a = MUL_BITS'(e2[0]); mul_b = MUL_BITS'(du1); end
               4'd9:    begin mul_a = MUL_BITS'(e1[0]); mul_b = MUL_BITS'(du2); end
               4'd10:   begin mul_a = MUL_BITS'(e2[1]); mul_b = MUL_BITS'(du1); end
               4'd11:   begin mul_a = MUL_BITS'(e1[1]); mul_b = MUL_BITS'(du2); end
               4'd12:   begin mul_a = MUL_BITS'(e2[2]); mul_b = MUL_BITS'(du1); end
               4'd13:   begin mul_a = MUL_BITS'(e1[2]); mul_b = MUL_BITS'(du2); end
               default: begin mul_a = '0;               mul_b = '0;             end
            endcase
         end
         ST_SQ: begin
            if (step_ff < STEP_BITS'(SQ_OPS)) begin
               mul_a = MUL_BITS'(tm_ff[step_ff[1:0]][TAN_TOP:0]);
               mul_b = MUL_BITS'(tm_ff[step_ff[1:0]][TAN_TOP:0]);
            end
         end
         ST_CORNER: begin
            case (step_ff)
               4'd0:    begin mul_a = MUL_BITS'(cur.norm_y); mul_b = MUL_BITS'(t_ff[2]); end
               4'd1:    begin mul_a = MUL_BITS'(cur.norm_z); mul_b = MUL_BITS'(t_ff[1]); end
               4'd2:    begin mul_a = MUL_BITS'(cur.norm_z); mul_b = MUL_BITS'(t_ff[0]); end
               4'd3:    begin mul_a = MUL_BITS'(cur.norm_x); mul_b = MUL_BITS'(t_ff[2]); end
               4'd4:    begin mul_a = MUL_BITS'(cur.norm_x); mul_b = MUL_BITS'(t_ff[1]); end
               4'd5:    begin mul_a = MUL_BITS'(cur.norm_y); mul_b = MUL_BITS'(t_ff[0]); end
               4'd6:    begin mul_a = c_ff[0];               mul_b = MUL_BITS'(b_ff[0]); end
               4'd7:    begin mul_a = c_ff[1];               mul_b = MUL_BITS'(b_ff[1]); end
               4'd8:    begin mul_a = c_ff[2];               mul_b = MUL_BITS'(b_ff[2]); end
               default: begin mul_a = '0;                    mul_b = '0;                 end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // next state and datapath
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      comp_in   = comp_ff;
      count_in  = count_ff;
      held_in   = held_ff;
      last_in   = last_ff;
      det_in    = det_ff;
      tmp_in    = tmp_ff;
      tr_in     = tr_ff;
      br_in     = br_ff;
      tm_in     = tm_ff;
      bm_in     = bm_ff;
      tneg_in   = tneg_ff;
      bneg_in   = bneg_ff;
      degen_in  = degen_ff;
      sum_in    = sum_ff;
      len_in    = len_ff;
      t_in      = t_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      rt_in     = rt_ff;
      rhand_in  = rhand_ff;
      rdegen_in = rdegen_ff;
      rlast_in  = rlast_ff;
      sq_cmd    = '{start: 1'b0, is_root: 1'b0};
      trs       = '0;
      brs       = '0;
      diff_raw  = tmp_ff - $signed(prod_ff[RAW_BITS-1:0]);
      ret_idx   = 3'(step_ff[STEP_BITS-1:1] - 1'b1);
      tall      = tm_ff[0] | tm_ff[1] | tm_ff[2];
      ball      = bm_ff[0] | bm_ff[1] | bm_ff[2];
      quo       = sq_res[QUO_BITS-1:0];
      qs        = $signed(OUT_BITS'(quo));
      dsum      = d_ff + $signed(prod_ff[DOT_BITS-1:0]);
      ci        = 2'(ret_idx);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (count_ff == 2'd2) begin
                  // third corner completes the triangle
                  last_in  = req_corner;
                  count_in = 2'd0;
                  step_in  = '0;
                  state_in = ST_PROD;
               end else begin
                  held_in[count_ff[0]] = req_corner;
                  count_in = count_ff + 1'b1;
               end
            end
         end

         ST_PROD: begin
            // each raw value is a difference of two products
            if (step_ff[0]) begin
               tmp_in = $signed(prod_ff[RAW_BITS-1:0]);
            end else if (step_ff != '0) begin
               if (ret_idx == 3'd0) begin
                  det_in = diff_raw;
               end else if (ret_idx < 3'd4) begin
                  tr_in[2'(ret_idx - 3'd1)] = diff_raw;
               end else begin
                  br_in[2'(ret_idx - 3'd4)] = diff_raw;
               end
            end
            if (step_ff == STEP_BITS'(PROD_OPS)) begin
               state_in = ST_ABS;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         ST_ABS: begin
            // orient by the sign of the uv determinant, split sign and magnitude
            for (int i = 0; i < 3; i++) begin
               trs = det_ff[RAW_BITS-1] ? -tr_ff[i] : tr_ff[i];
               brs = det_ff[RAW_BITS-1] ? -br_ff[i] : br_ff[i];
               tneg_in[i] = trs[RAW_BITS-1];
               bneg_in[i] = brs[RAW_BITS-1];
               tm_in[i] = trs[RAW_BITS-1] ? MAG_BITS'(-trs) : MAG_BITS'(trs);
               bm_in[i] = brs[RAW_BITS-1] ? MAG_BITS'(-brs) : MAG_BITS'(brs);
            end
            degen_in = (det_ff == '0) || ((tm_in[0] | tm_in[1] | tm_in[2]) == '0);
            if (degen_in) begin
               for (int i = 0; i < 3; i++) begin
                  t_in[i] = '0;
                  b_in[i] = '0;
               end
               comp_in  = 2'd0;
               step_in  = '0;
               state_in = ST_CORNER;
            end else begin
               state_in = ST_SCALE_T;
            end
         end

         ST_SCALE_T: begin
            // one bit a cycle until the largest magnitude sits in the window
            if (tall[MAG_BITS-1:TAN_TOP+1] != '0) begin
               for (int i = 0; i < 3; i++) tm_in[i] = tm_ff[i] >> 1;
            end else if (!tall[TAN_TOP]) begin
               for (int i = 0; i < 3; i++) tm_in[i] = tm_ff[i] << 1;
            end else begin
               sum_in   = '0;
               step_in  = '0;
               state_in = ST_SQ;
            end
         end

         ST_SQ: begin
            if (step_ff != '0) begin
               sum_in = sum_ff + prod_ff[SUM_BITS-1:0];
            end
            if (step_ff == STEP_BITS'(SQ_OPS)) begin
               step_in  = '0;
               state_in = ST_ROOT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         ST_ROOT: begin
            if (step_ff == '0) begin
               sq_cmd  = '{start: 1'b1, is_root: 1'b1};
               step_in = STEP_BITS'(1);
            end else if (sq_done) begin
               len_in   = sq_res[ROOT_BITS-1:0];
               comp_in  = 2'd0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            // rounded quotient per tangent component, sign put back
            if (step_ff == '0) begin
               sq_cmd  = '{start: 1'b1, is_root: 1'b0};
               step_in = STEP_BITS'(1);
            end else if (sq_done) begin
               t_in[comp_ff] = tneg_ff[comp_ff] ? -qs : qs;
               step_in = '0;
               if (comp_ff == 2'd2) begin
                  comp_in  = 2'd0;
                  state_in = ST_SCALE_B;
               end else begin
                  comp_in = comp_ff + 1'b1;
               end
            end
         end

         ST_SCALE_B: begin
            if (ball == '0) begin
               for (int i = 0; i < 3; i++) b_in[i] = '0;
               comp_in  = 2'd0;
               step_in  = '0;
               state_in = ST_CORNER;
            end else if (ball[MAG_BITS-1:BIT_TOP+1] != '0) begin
               for (int i = 0; i < 3; i++) bm_in[i] = bm_ff[i] >> 1;
            end else if (!ball[BIT_TOP]) begin
               for (int i = 0; i < 3; i++) bm_in[i] = bm_ff[i] << 1;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  b_in[i] = bneg_ff[i] ? -$signed(OUT_BITS'(bm_ff[i][BIT_TOP:0]))
                                       :  $signed(OUT_BITS'(bm_ff[i][BIT_TOP:0]));
               end
               comp_in  = 2'd0;
               step_in  = '0;
               state_in = ST_CORNER;
            end
         end

         ST_CORNER: begin
            // cross(normal, tangent) in six products, then the dot with the bitangent
            if (step_ff[0] && step_ff < STEP_BITS'(6)) begin
               tmp_in = $signed(prod_ff[RAW_BITS-1:0]);
            end else if (!step_ff[0] && step_ff != '0 && step_ff <= STEP_BITS'(6)) begin
               c_in[ci] = CR_BITS'(tmp_ff) - $signed(prod_ff[CR_BITS-1:0]);
            end
            if (step_ff == STEP_BITS'(7)) begin
               d_in = $signed(prod_ff[DOT_BITS-1:0]);
            end else if (step_ff == STEP_BITS'(8)) begin
               d_in = dsum;
            end
            if (step_ff == STEP_BITS'(CORNER_END)) begin
               rt_in     = t_ff;
               rhand_in  = dsum[DOT_BITS-1];
               rdegen_in = degen_ff;
               rlast_in  = (comp_ff == 2'd2);
               state_in  = ST_OUT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         ST_OUT: begin
            if (!rsp_stall) begin
               step_in = '0;
               if (comp_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end else begin
                  comp_in  = comp_ff + 1'b1;
                  state_in = ST_CORNER;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= 2'd0;
         step_ff  <= '0;
         comp_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff  <= step_in;
         comp_ff  <= comp_in;
      end
      held_ff   <= held_in;
      last_ff   <= last_in;
      det_ff    <= det_in;
      tmp_ff    <= tmp_in;
      tr_ff     <= tr_in;
      br_ff     <= br_in;
      tm_ff     <= tm_in;
      bm_ff     <= bm_in;
      tneg_ff   <= tneg_in;
      bneg_ff   <= bneg_in;
      degen_ff  <= degen_in;
      sum_ff    <= sum_in;
      len_ff    <= len_in;
      t_ff      <= t_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      d_ff      <= d_in;
      rt_ff     <= rt_in;
      rhand_ff  <= rhand_in;
      rdegen_ff <= rdegen_in;
      rlast_ff  <= rlast_in;
   end

`ifndef SYNTHESIS
   // a degenerate triangle carries a zero tangent and positive handedness
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_tangent_x == '0 && rsp_tangent_y == '0 && rsp_tangent_z == '0 &&
         !rsp_handed_negative)
      else $error("degenerate result with nonzero tangent or negative handedness");

   // normalised components never exceed one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_tangent_x <= 16'sd16384 && rsp_tangent_x >= -16'sd16384 &&
         rsp_tangent_y <= 16'sd16384 && rsp_tangent_y >= -16'sd16384 &&
         rsp_tangent_z <= 16'sd16384 && rsp_tangent_z >= -16'sd16384)
      else $error("tangent component out of range");

   // the third corner transfer starts the sequencer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && count_ff == 2'd2 |=> state_ff == ST_PROD)
      else $error("third corner did not start the triangle");

   // the shared unit only finishes while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      sq_done |-> state_ff == ST_ROOT || state_ff == ST_DIV)
      else $error("root or divide finished outside its wait state");
`endif

endmodule

// ===== rtl/core/ttf_mul.sv =====
// ttf_mul: shared signed multiplier with registered product
// depends on ttf_pkg

module ttf_mul (
   input  logic                                  clock,
   input  logic signed [ttf_pkg::MUL_BITS-1:0]   op_a,
   input  logic signed [ttf_pkg::MUL_BITS-1:0]   op_b,
   output logic signed [ttf_pkg::PROD_BITS-1:0]  prod_ff
);
   import ttf_pkg::*;

   logic signed [PROD_BITS-1:0] prod_in;

   assign prod_in = PROD_BITS'(op_a) * PROD_BITS'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/core/ttf_sqdiv.sv =====
// ttf_sqdiv: iterative integer square root and divider on one compare-subtract
// depends on ttf_pkg

module ttf_sqdiv (
   input  logic                            clock,
   input  logic                            reset,
   input  ttf_pkg::sqdiv_cmd_type          cmd,
   input  logic [ttf_pkg::SUM_BITS-1:0]    root_arg,
   input  logic [ttf_pkg::NUM_BITS-1:0]    num,
   input  logic [ttf_pkg::DEN_BITS-1:0]    den,
   output logic                            done_ff,
   output logic [ttf_pkg::ACC_BITS-1:0]    res_ff
);
   import ttf_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_in;
   logic                root_ff, root_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [ACC_BITS-1:0] acc_ff, acc_in;
   logic [ACC_BITS-1:0] res_in;
   logic [ACC_BITS-1:0] bit_ff, bit_in;
   logic [DEN_BITS-1:0] den_ff, den_in;

   logic [ACC_BITS-1:0] rem2, op_a, op_b;
   logic [ACC_BITS:0]   diff;
   logic                ge;

   // one compare-subtract shared by both operations
   assign rem2 = {acc_ff[ACC_BITS-2:0], bit_ff[ACC_BITS-1]};
   assign op_a = root_ff ? acc_ff : rem2;
   assign op_b = root_ff ? (res_ff + bit_ff) : ACC_BITS'(den_ff);
   assign diff = {1'b0, op_a} - {1'b0, op_b};
   assign ge   = ~diff[ACC_BITS];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      den_in  = den_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         root_in = cmd.is_root;
         res_in  = '0;
         den_in  = den;
         if (cmd.is_root) begin
            cnt_in = CNT_BITS'(ROOT_STEPS - 1);
            acc_in = ACC_BITS'(root_arg);
            bit_in = ACC_BITS'(1) << (2 * (ROOT_STEPS - 1));
         end else begin
            cnt_in = CNT_BITS'(DIV_STEPS - 1);
            acc_in = ACC_BITS'(num >> DIV_STEPS);
            bit_in = {num[DIV_STEPS-1:0], {(ACC_BITS-DIV_STEPS){1'b0}}};
         end
      end else if (busy_ff) begin
         acc_in = ge ? diff[ACC_BITS-1:0] : op_a;
         if (root_ff) begin
            res_in = ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
            bit_in = bit_ff >> 2;
         end else begin
            res_in = {res_ff[ACC_BITS-2:0], ge};
            bit_in = bit_ff << 1;
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      den_ff  <= den_in;
   end

endmodule

// ===== verif/tb_triangle_tangent_frame.sv =====
// tb_triangle_tangent_frame: self-checking testbench for the tangent frame block
// holds a scoreboard class with its own integer tangent predictor
// depends on ttf_pkg and the triangle_tangent_frame rtl

module tb_triangle_tangent_frame;
   timeunit 1ns;
   timeprecision 1ps;
   import ttf_pkg::*;

   typedef struct {
      logic signed [15:0] tan_x;
      logic signed [15:0] tan_y;
      logic signed [15:0] tan_z;
      logic               neg;
      logic               degen;
      logic               last;
   } frame_type;

   // magnitude of a signed 64-bit value
   function automatic longint unsigned abs64(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   // common shift so the largest magnitude sits in [2^top, 2^(top+1))
   function automatic void shift_window(ref longint unsigned m[3], input int top);
      longint unsigned all;
      all = m[0] | m[1] | m[2];
      if (all == 0) return;
      while ((all >> (top + 1)) != 0) begin
         foreach (m[i]) m[i] = m[i] >> 1;
         all = all >> 1;
      end
      while ((all >> top) == 0) begin
         foreach (m[i]) m[i] = m[i] << 1;
         all = all << 1;
      end
   endfunction

   function automatic longint unsigned int_root(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   class frame_scoreboard;
      corner_type held[2];
      int         held_count;
      frame_type  pending[$];
      int         errors;
      int         frames_seen;
      int         degen_seen;

      function void note_corner(corner_type c);
         corner_type cn[3];
         longint p[3][3], e1[3], e2[3], tr[3], br[3], tv[3], bv[3];
         longint unsigned tm[3], bm[3], sum, len, q;
         longint du1, dv1, du2, dv2, det, nx, ny, nz, cx, cy, cz, d;
         bit dg;
         frame_type f;
         if (held_count < 2) begin
            held[held_count] = c;
            held_count++;
            return;
         end
         held_count = 0;
         cn[0] = held[0];
         cn[1] = held[1];
         cn[2] = c;
         foreach (cn[k]) begin
            p[k][0] = cn[k].pos_x;
            p[k][1] = cn[k].pos_y;
            p[k][2] = cn[k].pos_z;
         end
         du1 = longint'(cn[1].tex_u) - cn[0].tex_u;
         dv1 = longint'(cn[1].tex_v) - cn[0].tex_v;
         du2 = longint'(cn[2].tex_u) - cn[0].tex_u;
         dv2 = longint'(cn[2].tex_v) - cn[0].tex_v;
         det = du1 * dv2 - du2 * dv1;
         for (int i = 0; i < 3; i++) begin
            e1[i] = p[1][i] - p[0][i];
            e2[i] = p[2][i] - p[0][i];
            tr[i] = e1[i] * dv2 - e2[i] * dv1;
            br[i] = e2[i] * du1 - e1[i] * du2;
            if (det < 0) begin
               tr[i] = -tr[i];
               br[i] = -br[i];
            end
            tm[i] = abs64(tr[i]);
            bm[i] = abs64(br[i]);
            tv[i] = 0;
            bv[i] = 0;
         end
         dg = (det == 0) || ((tm[0] | tm[1] | tm[2]) == 0);
         if (!dg) begin
            shift_window(tm, TAN_TOP);
            sum = tm[0] * tm[0] + tm[1] * tm[1] + tm[2] * tm[2];
            len = int_root(sum);
            for (int i = 0; i < 3; i++) begin
               q = (tm[i] * 64'd32768 + len) / (2 * len);
               tv[i] = tr[i] < 0 ? -longint'(q) : longint'(q);
            end
            shift_window(bm, BIT_TOP);
            for (int i = 0; i < 3; i++) bv[i] = br[i] < 0 ? -longint'(bm[i]) : longint'(bm[i]);
         end
         for (int k = 0; k < 3; k++) begin
            nx = cn[k].norm_x;
            ny = cn[k].norm_y;
            nz = cn[k].norm_z;
            cx = ny * tv[2] - nz * tv[1];
            cy = nz * tv[0] - nx * tv[2];
            cz = nx * tv[1] - ny * tv[0];
            d = cx * bv[0] + cy * bv[1] + cz * bv[2];
            f.tan_x = tv[0][15:0];
            f.tan_y = tv[1][15:0];
            f.tan_z = tv[2][15:0];
            f.neg = d < 0;
            f.degen = dg;
            f.last = (k == 2);
            pending.insert(pending.size(), f);
         end
         frames_seen++;
         if (dg) degen_seen++;
      endfunction

      function void check_frame(frame_type got);
         frame_type w;
         if (pending.size() == 0) begin
            $error("result transfer with nothing expected");
            errors++;
            return;
         end
         w = pending.pop_front();
         if (got.tan_x !== w.tan_x) begin
            $error("tangent_x expected %0d got %0d", w.tan_x, got.tan_x); errors++;
         end
         if (got.tan_y !== w.tan_y) begin
            $error("tangent_y expected %0d got %0d", w.tan_y, got.tan_y); errors++;
         end
         if (got.tan_z !== w.tan_z) begin
            $error("tangent_z expected %0d got %0d", w.tan_z, got.tan_z); errors++;
         end
         if (got.neg !== w.neg) begin
            $error("handed_negative expected %0b got %0b", w.neg, got.neg); errors++;
         end
         if (got.degen !== w.degen) begin
            $error("degenerate expected %0b got %0b", w.degen, got.degen); errors++;
         end
         if (got.last !== w.last) begin
            $error("last_corner expected %0b got %0b", w.last, got.last); errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [15:0] req_tex_u = '0, req_tex_v = '0;
   logic signed [15:0] req_norm_x = '0, req_norm_y = '0, req_norm_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_tangent_x, rsp_tangent_y, rsp_tangent_z;
   logic rsp_handed_negative, rsp_degenerate, rsp_last_corner;

   frame_scoreboard sb;
   int  cycles = 0;
   int  corners_sent;
   // receiver stall pattern: mode 0 never stalls, 1 random, 2 long bursts
   int  stall_mode = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   triangle_tangent_frame u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_tex_u(req_tex_u), .req_tex_v(req_tex_v),
      .req_norm_x(req_norm_x), .req_norm_y(req_norm_y), .req_norm_z(req_norm_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_tangent_x(rsp_tangent_x), .rsp_tangent_y(rsp_tangent_y),
      .rsp_tangent_z(rsp_tangent_z), .rsp_handed_negative(rsp_handed_negative),
      .rsp_degenerate(rsp_degenerate), .rsp_last_corner(rsp_last_corner)
   );

   // result side: sample on the rising edge, note what was transferred
   always @(posedge clock) begin
      frame_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.tan_x = rsp_tangent_x;
         got.tan_y = rsp_tangent_y;
         got.tan_z = rsp_tangent_z;
         got.neg   = rsp_handed_negative;
         got.degen = rsp_degenerate;
         got.last  = rsp_last_corner;
         sb.check_frame(got);
      end
   end

   // receiver stall pattern, changed on the falling edge
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
         default: begin
            if ($urandom_range(0, 7) == 0) rsp_stall <= ~rsp_stall;
         end
      endcase
   end

   // watchdog: the slowest triangle plus stalls stays far below this limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // one corner transfer: payload set on the falling edge, held until taken
   task automatic send_corner(input corner_type c);
      req_valid  <= 1'b1;
      req_pos_x  <= c.pos_x;
      req_pos_y  <= c.pos_y;
      req_pos_z  <= c.pos_z;
      req_tex_u  <= c.tex_u;
      req_tex_v  <= c.tex_v;
      req_norm_x <= c.norm_x;
      req_norm_y <= c.norm_y;
      req_norm_z <= c.norm_z;
      do @(posedge clock); while (req_stall);
      sb.note_corner(c);
      corners_sent++;
      @(negedge clock);
   endtask

   // sender gap between bursts; valid is dropped here and at the end of the run
   task automatic sender_gap(input int n);
      if (n == 0) return;
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   function automatic corner_type rand_corner(input bit wild);
      corner_type c;
      c.pos_x = $urandom;
      c.pos_y = $urandom;
      c.pos_z = $urandom;
      c.tex_u = $urandom;
      c.tex_v = $urandom;
      if (wild) begin
         c.norm_x = $urandom;
         c.norm_y = $urandom;
         c.norm_z = $urandom;
      end else begin
         c.norm_x = $urandom_range(0, 32768) - 16384;
         c.norm_y = $urandom_range(0, 32768) - 16384;
         c.norm_z = $urandom_range(0, 32768) - 16384;
      end
      // small coordinates now and then, so short edges and tiny uv deltas occur
      if ($urandom_range(0, 3) == 0) begin
         c.pos_x = $signed(c.pos_x) >>> $urandom_range(6, 15);
         c.pos_y = $signed(c.pos_y) >>> $urandom_range(6, 15);
         c.pos_z = $signed(c.pos_z) >>> $urandom_range(6, 15);
         c.tex_u = $signed(c.tex_u) >>> $urandom_range(6, 15);
         c.tex_v = $signed(c.tex_v) >>> $urandom_range(6, 15);
      end
      return c;
   endfunction

   function automatic corner_type mk(input int px, py, pz, u, v, nx, ny, nz);
      corner_type c;
      c.pos_x = px; c.pos_y = py; c.pos_z = pz;
      c.tex_u = u;  c.tex_v = v;
      c.norm_x = nx; c.norm_y = ny; c.norm_z = nz;
      return c;
   endfunction

   initial begin
      corner_type c, base;
      int burst;
      sb = new();
      corners_sent = 0;
      base = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // plain right-handed triangle; the third corner's flipped normal gives negative handedness
      send_corner(mk(0, 0, 0, 0, 0, 0, 0, 16384));
      send_corner(mk(256, 0, 0, 16384, 0, 0, 0, 16384));
      send_corner(mk(0, 256, 0, 0, 16384, 0, 0, -16384));
      // mirrored uv, negative determinant
      send_corner(mk(0, 0, 0, 0, 0, 16384, 0, 0));
      send_corner(mk(256, 0, 0, -16384, 0, 0, 16384, 0));
      send_corner(mk(0, 0, 256, 0, 16384, 0, 0, 16384));
      // zero uv determinant: degenerate
      send_corner(mk(100, 200, 300, 5, 5, 0, 0, 16384));
      send_corner(mk(-100, 20, 3, 5, 5, 0, 16384, 0));
      send_corner(mk(7, -9, 11, 5, 5, 16384, 0, 0));
      // non-zero determinant, zero raw tangent (all positions equal)
      send_corner(mk(50, 50, 50, 0, 0, 0, 0, 16384));
      send_corner(mk(50, 50, 50, 16384, 0, 0, 0, 16384));
      send_corner(mk(50, 50, 50, 0, 16384, 0, 0, 16384));
      // zero bitangent: e1 parallel to e2 with matching uv ratio
      send_corner(mk(0, 0, 0, 0, 0, 0, 0, 16384));
      send_corner(mk(256, 0, 0, 100, 50, 0, 16384, 0));
      send_corner(mk(512, 0, 0, 200, 101, 0, 0, 16384));
      // field extremes, out-of-range normals
      send_corner(mk(-32768, 32767, -32768, -32768, 32767, -32768, 32767, -32768));
      send_corner(mk(32767, -32768, 32767, 32767, -32768, 32767, -32768, 32767));
      send_corner(mk(-32768, -32768, 32767, 32767, 32767, 16384, -16384, 0));
      send_corner(mk(32767, 32767, 32767, -32768, -32768, -16384, 16384, 16384));
      send_corner(mk(-1, -1, -1, -1, -1, -1, -1, -1));
      send_corner(mk(0, 0, 0, 32767, -32768, 0, 0, 0));

      // random: mostly well-formed triangles, some wild normals and flat uv
      while (corners_sent < 320) begin
         burst = $urandom_range(1, 9);
         for (int i = 0; i < burst; i++) begin
            c = rand_corner($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 15) == 0) begin
               c.tex_u = base.tex_u;
               c.tex_v = base.tex_v;
            end
            base = c;
            send_corner(c);
         end
         if ($urandom_range(0, 2) != 0) sender_gap($urandom_range(1, 40));
      end
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d corners, %0d triangles of which %0d degenerate",
               corners_sent, sb.frames_seen, sb.degen_seen);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/core/ttf_pkg.sv
rtl/core/ttf_mul.sv
rtl/core/ttf_sqdiv.sv
rtl/core/triangle_tangent_frame.sv
verif/tb_triangle_tangent_frame.sv
